### rtl/core/ptts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg: shared types and constants of the priority tick thread scheduler
// Item modes, register indexes, field widths, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptts_pkg;

   localparam int MODE_W      = 3;
   localparam int THREAD_W    = 3;
   localparam int TIMEOUT_W   = 16;
   localparam int PRIO_W      = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [PRIO_W-1:0] PRIO_NEVER = 8'hFF;

   localparam logic [MODE_W-1:0] MODE_TICK         = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SCHED_THREAD = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SCHED_IRQ    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SCHED_SELF   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DISPATCH     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DONE         = 3'd5;
   localparam logic [MODE_W-1:0] MODE_REGISTER     = 3'd6;

   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_NOW = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEEP   = 1'b1;

   localparam logic [CSR_DATA_W-1:0] RUN_NOW_RESET = 16'd1;
   localparam logic [CSR_DATA_W-1:0] SLEEP_RESET   = 16'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN_THREAD,
      ST_DRAIN_IRQ,
      ST_DECREMENT,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic pop_thread;
      logic pop_irq;
      logic decrement;
      logic scan_read;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic thread_q_empty;
      logic irq_q_empty;
      logic scan_last;
      logic rsp_free;
   } ctrl_status_type;

endpackage

### rtl/core/ptts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_queue: deferred timer write queue
// Circular buffer in a memory with registered read data; one push or one
// pop per cycle, the caller never pushes when full or pops when empty.
// ----------------------------------------------------------------------------
module ptts_queue #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 19
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] pop_data_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         count_in  = count_ff + CNT_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         count_in  = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pop_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign pop_data = pop_data_ff;
   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);

endmodule

### rtl/core/ptts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_ctrl: scheduler controller
// Sequences one item at a time: the updates in the execute state, the tick drain and
// decrement, the dispatch scan over the priority memory and the response.
// ----------------------------------------------------------------------------
module ptts_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [ptts_pkg::MODE_W-1:0]     req_mode,
   output logic                            req_ready,
   input  ptts_pkg::ctrl_status_type       status,
   output ptts_pkg::ctrl_cmd_type          cmd
);

   ptts_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptts_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  ptts_pkg::MODE_TICK:     state_in = ptts_pkg::ST_DRAIN_THREAD;
                  ptts_pkg::MODE_DISPATCH: state_in = ptts_pkg::ST_SCAN;
                  default:                 state_in = ptts_pkg::ST_EXEC;
               endcase
            end
         end
         ptts_pkg::ST_EXEC: state_in = ptts_pkg::ST_RESPOND;
         ptts_pkg::ST_DRAIN_THREAD: begin
            if (status.thread_q_empty) begin
               state_in = ptts_pkg::ST_DRAIN_IRQ;
            end
         end
         ptts_pkg::ST_DRAIN_IRQ: begin
            if (status.irq_q_empty) begin
               state_in = ptts_pkg::ST_DECREMENT;
            end
         end
         ptts_pkg::ST_DECREMENT: state_in = ptts_pkg::ST_RESPOND;
         ptts_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ptts_pkg::ST_SCAN_LAST;
            end
         end
         ptts_pkg::ST_SCAN_LAST: state_in = ptts_pkg::ST_RESPOND;
         ptts_pkg::ST_RESPOND: begin
            if (status.rsp_free) begin
               state_in = ptts_pkg::ST_IDLE;
            end
         end
         default: state_in = ptts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ptts_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ptts_pkg::ST_EXEC:         cmd.exec       = 1'b1;
         ptts_pkg::ST_DRAIN_THREAD: cmd.pop_thread = !status.thread_q_empty;
         ptts_pkg::ST_DRAIN_IRQ:    cmd.pop_irq    = !status.irq_q_empty;
         ptts_pkg::ST_DECREMENT:    cmd.decrement  = 1'b1;
         ptts_pkg::ST_SCAN:         cmd.scan_read  = 1'b1;
         ptts_pkg::ST_RESPOND:      cmd.respond    = status.rsp_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### rtl/core/ptts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_dp: scheduler datapath
// Thread state (ready flags, timer lanes, priority memory), the two deferred
// write queues, the dispatch compare, the registers and the response beat.
// ----------------------------------------------------------------------------
module ptts_dp #(
   parameter int NUM_THREADS = 8,
   parameter int QUEUE_DEPTH = 16,
   parameter int TIMER_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ptts_pkg::ctrl_cmd_type              cmd,
   output ptts_pkg::ctrl_status_type           status,
   input  logic [ptts_pkg::MODE_W-1:0]         req_mode,
   input  logic [ptts_pkg::THREAD_W-1:0]       req_thread,
   input  logic [ptts_pkg::TIMEOUT_W-1:0]      req_timeout,
   input  logic [ptts_pkg::PRIO_W-1:0]         req_priority_req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_dispatched,
   output logic [ptts_pkg::THREAD_W-1:0]       rsp_dispatch_thread,
   output logic                                rsp_dropped,
   input  logic                                csr_write_en,
   input  logic [ptts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ptts_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int IDX_W   = $clog2(NUM_THREADS);
   localparam int WIDE_W  = IDX_W + ptts_pkg::THREAD_W;
   localparam int ENTRY_W = ptts_pkg::THREAD_W + TIMER_BITS;
   localparam logic [WIDE_W-1:0]     THREADS_WIDE = WIDE_W'(NUM_THREADS);
   localparam logic [IDX_W-1:0]      IDX_LAST     = IDX_W'(NUM_THREADS - 1);
   localparam logic [TIMER_BITS-1:0] TIMER_ONE    = TIMER_BITS'(1);

   // latched item
   logic [ptts_pkg::MODE_W-1:0]    mode_ff;
   logic [ptts_pkg::THREAD_W-1:0]  thread_ff;
   logic [ptts_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [ptts_pkg::PRIO_W-1:0]    prio_req_ff;

   logic [ptts_pkg::CSR_DATA_W-1:0] run_now_ff, sleep_ff;

   logic [NUM_THREADS-1:0] ready_ff, ready_in;
   logic [TIMER_BITS-1:0]  countdown_ff [NUM_THREADS];
   logic [TIMER_BITS-1:0]  countdown_in [NUM_THREADS];
   logic [ptts_pkg::THREAD_W-1:0] running_ff;

   logic [ptts_pkg::PRIO_W-1:0] prio_mem [NUM_THREADS];
   logic [NUM_THREADS-1:0]      prio_vld_ff;
   logic [ptts_pkg::PRIO_W-1:0] prio_q_ff;
   logic                        prio_qv_ff;

   logic [IDX_W-1:0]            scan_idx_ff, cmp_idx_ff, pick_ff;
   logic                        cmp_valid_ff, found_ff, drop_ff;
   logic [ptts_pkg::PRIO_W-1:0] best_ff;

   logic wb_valid_ff, wb_irq_ff;

   logic                          rsp_valid_ff, rsp_dispatched_ff, rsp_dropped_ff;
   logic [ptts_pkg::THREAD_W-1:0] rsp_thread_ff;

   // queue ports
   logic               tq_push, iq_push, tq_full, iq_full, tq_empty, iq_empty;
   logic [ENTRY_W-1:0] tq_push_data, iq_push_data, tq_pop_data, iq_pop_data;

   // decode
   logic [WIDE_W-1:0] thr_wide, run_wide, wb_wide, pick_wide;
   logic              thr_ok, run_ok, wb_ok;
   logic [IDX_W-1:0]  thr_idx, run_idx, wb_idx;
   logic [ptts_pkg::THREAD_W-1:0] pick_narrow;
   logic [ENTRY_W-1:0]    wb_entry;
   logic [TIMER_BITS-1:0] wb_value, timeout_timer;
   logic is_sched_t, is_sched_i, is_self, is_reg, is_done;
   logic immediate, drop_set;
   logic [ptts_pkg::PRIO_W-1:0] eff_prio;
   logic hit;

   assign thr_wide = WIDE_W'(thread_ff);
   assign thr_ok   = (thr_wide < THREADS_WIDE);
   assign thr_idx  = thr_wide[IDX_W-1:0];
   assign run_wide = WIDE_W'(running_ff);
   assign run_ok   = (run_wide < THREADS_WIDE);
   assign run_idx  = run_wide[IDX_W-1:0];

   assign timeout_timer = TIMER_BITS'(timeout_ff);

   assign wb_entry = wb_irq_ff ? iq_pop_data : tq_pop_data;
   assign wb_wide  = WIDE_W'(wb_entry[ENTRY_W-1 -: ptts_pkg::THREAD_W]);
   assign wb_ok    = (wb_wide < THREADS_WIDE);
   assign wb_idx   = wb_wide[IDX_W-1:0];
   assign wb_value = wb_entry[TIMER_BITS-1:0];

   assign pick_wide   = WIDE_W'(pick_ff);
   assign pick_narrow = pick_wide[ptts_pkg::THREAD_W-1:0];

   assign is_sched_t = cmd.exec && (mode_ff == ptts_pkg::MODE_SCHED_THREAD) && thr_ok;
   assign is_sched_i = cmd.exec && (mode_ff == ptts_pkg::MODE_SCHED_IRQ) && thr_ok;
   assign is_self    = cmd.exec && (mode_ff == ptts_pkg::MODE_SCHED_SELF);
   assign is_reg     = cmd.exec && (mode_ff == ptts_pkg::MODE_REGISTER) && thr_ok;
   assign is_done    = cmd.exec && (mode_ff == ptts_pkg::MODE_DONE) && run_ok;

   // a full queue drops the whole request, immediate flag change included
   assign tq_push   = (is_sched_t || is_self) && !tq_full;
   assign iq_push   = is_sched_i && !iq_full;
   assign drop_set  = ((is_sched_t || is_self) && tq_full) || (is_sched_i && iq_full);
   assign immediate = (is_sched_t && !tq_full) || iq_push;

   assign tq_push_data = is_self ? {running_ff, timeout_timer} : {thread_ff, timeout_timer};
   assign iq_push_data = {thread_ff, timeout_timer};

   ptts_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_thread_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tq_push),
      .push_data (tq_push_data),
      .pop       (cmd.pop_thread),
      .pop_data  (tq_pop_data),
      .full      (tq_full),
      .empty     (tq_empty)
   );

   ptts_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_irq_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (iq_push),
      .push_data (iq_push_data),
      .pop       (cmd.pop_irq),
      .pop_data  (iq_pop_data),
      .full      (iq_full),
      .empty     (iq_empty)
   );

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff     <= req_mode;
         thread_ff   <= req_thread;
         timeout_ff  <= req_timeout;
         prio_req_ff <= req_priority_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_now_ff <= ptts_pkg::RUN_NOW_RESET;
         sleep_ff   <= ptts_pkg::SLEEP_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            ptts_pkg::CSR_RUN_NOW: run_now_ff <= csr_write_data;
            ptts_pkg::CSR_SLEEP:   sleep_ff   <= csr_write_data;
            default: begin
               run_now_ff <= run_now_ff;
            end
         endcase
      end
   end

   always_comb begin
      ready_in = ready_ff;
      if (immediate) begin
         if (timeout_ff == run_now_ff) begin
            ready_in[thr_idx] = 1'b1;
         end else if (timeout_ff == sleep_ff) begin
            ready_in[thr_idx] = 1'b0;
         end
      end
      if (is_done) begin
         ready_in[run_idx] = 1'b0;
      end
      if (cmd.decrement) begin
         for (int i = 0; i < NUM_THREADS; i++) begin
            if (countdown_ff[i] == TIMER_ONE) begin
               ready_in[i] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      countdown_in = countdown_ff;
      if (wb_valid_ff && wb_ok) begin
         countdown_in[wb_idx] = wb_value;
      end
      if (is_reg) begin
         countdown_in[thr_idx] = timeout_timer;
      end
      if (cmd.decrement) begin
         for (int i = 0; i < NUM_THREADS; i++) begin
            if (countdown_ff[i] != '0) begin
               countdown_in[i] = countdown_ff[i] - TIMER_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= '0;
         countdown_ff <= '{default: '0};
         wb_valid_ff  <= 1'b0;
         wb_irq_ff    <= 1'b0;
      end else begin
         ready_ff     <= ready_in;
         countdown_ff <= countdown_in;
         wb_valid_ff  <= cmd.pop_thread || cmd.pop_irq;
         wb_irq_ff    <= cmd.pop_irq;
      end
   end

   // priority memory: an entry never registered reads as never picked
   always_ff @(posedge clock) begin
      if (is_reg) begin
         prio_mem[thr_idx] <= prio_req_ff;
      end
      if (cmd.scan_read) begin
         prio_q_ff <= prio_mem[scan_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_vld_ff <= '0;
         prio_qv_ff  <= 1'b0;
      end else begin
         if (is_reg) begin
            prio_vld_ff[thr_idx] <= 1'b1;
         end
         if (cmd.scan_read) begin
            prio_qv_ff <= prio_vld_ff[scan_idx_ff];
         end
      end
   end

   assign eff_prio = prio_qv_ff ? prio_q_ff : ptts_pkg::PRIO_NEVER;
   assign hit      = cmp_valid_ff && ready_ff[cmp_idx_ff] && (eff_prio < best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         cmp_idx_ff   <= '0;
         cmp_valid_ff <= 1'b0;
         best_ff      <= ptts_pkg::PRIO_NEVER;
         pick_ff      <= '0;
         found_ff     <= 1'b0;
         drop_ff      <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan_read;
         if (cmd.accept) begin
            scan_idx_ff <= '0;
            best_ff     <= ptts_pkg::PRIO_NEVER;
            pick_ff     <= '0;
            found_ff    <= 1'b0;
            drop_ff     <= 1'b0;
         end else begin
            if (cmd.scan_read) begin
               cmp_idx_ff  <= scan_idx_ff;
               scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            end
            if (hit) begin
               best_ff  <= eff_prio;
               pick_ff  <= cmp_idx_ff;
               found_ff <= 1'b1;
            end
            if (drop_set) begin
               drop_ff <= 1'b1;
            end
         end
      end
   end

   // response beat and running thread
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         running_ff   <= '0;
      end else begin
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.respond && found_ff) begin
            running_ff <= pick_narrow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_dispatched_ff <= found_ff;
         rsp_thread_ff     <= pick_narrow;
         rsp_dropped_ff    <= drop_ff;
      end
   end

   assign status.thread_q_empty = tq_empty;
   assign status.irq_q_empty    = iq_empty;
   assign status.scan_last      = (scan_idx_ff == IDX_LAST);
   assign status.rsp_free       = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_dispatched      = rsp_dispatched_ff;
   assign rsp_dispatch_thread = rsp_thread_ff;
   assign rsp_dropped         = rsp_dropped_ff;

endmodule

### rtl/core/priority_tick_thread_scheduler_top.sv
`timescale 1ns / 1ps
// Steps: schedule, done, register and unused items go through the execute state to the
//   response beat; dispatch scans (one priority memory read per thread);
//   tick drains both queues (one queue memory read per entry) and decrements the timers.
// Throughput: one item at a time; the next item is accepted the cycle after the response
//   is loaded into the output register. Reset empties queues, clears flags and timers.
// ----------------------------------------------------------------------------
// priority_tick_thread_scheduler_top: timer-driven priority thread scheduler
// Per-thread ready flags, countdown timers and priorities; deferred timer
// writes in a thread queue and an interrupt queue, drained on each tick.
// ----------------------------------------------------------------------------
module priority_tick_thread_scheduler_top #(
   parameter int NUM_THREADS = 8,
   parameter int QUEUE_DEPTH = 16,
   parameter int TIMER_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ptts_pkg::MODE_W-1:0]         req_mode,
   input  logic [ptts_pkg::THREAD_W-1:0]       req_thread,
   input  logic [ptts_pkg::TIMEOUT_W-1:0]      req_timeout,
   input  logic [ptts_pkg::PRIO_W-1:0]         req_priority_req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_dispatched,
   output logic [ptts_pkg::THREAD_W-1:0]       rsp_dispatch_thread,
   output logic                                rsp_dropped,
   input  logic                                csr_write_en,
   input  logic [ptts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ptts_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   ptts_pkg::ctrl_cmd_type    cmd;
   ptts_pkg::ctrl_status_type status;

   ptts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ptts_dp #(
      .NUM_THREADS (NUM_THREADS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIMER_BITS  (TIMER_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_mode),
      .req_thread          (req_thread),
      .req_timeout         (req_timeout),
      .req_priority_req    (req_priority_req),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_dispatched      (rsp_dispatched),
      .rsp_dispatch_thread (rsp_dispatch_thread),
      .rsp_dropped         (rsp_dropped),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

endmodule

### bench/priority_tick_thread_scheduler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_tick_thread_scheduler_top_tb: self-checking bench for the scheduler
// Drives a directed table and then randomized phases, each under a different
// setting of the run-now and sleep codes. An in-bench scheduler model
// predicts every response beat, and a scoreboard compares each beat by field.
// ----------------------------------------------------------------------------
module priority_tick_thread_scheduler_top_tb;

   localparam int CLK_PERIOD      = 10;
   localparam int NUM_THREADS     = 8;
   localparam int QUEUE_DEPTH     = 16;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 270;
   localparam int SEGMENT_ITEMS   = 40;
   localparam int SETTLE_CYCLES   = NUM_THREADS + 2 * QUEUE_DEPTH + 8;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int MAX_PRINTED     = 100;

   localparam logic [ptts_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;

   typedef struct packed {
      logic [ptts_pkg::MODE_W-1:0]    mode;
      logic [ptts_pkg::THREAD_W-1:0]  thread;
      logic [ptts_pkg::TIMEOUT_W-1:0] timeout;
      logic [ptts_pkg::PRIO_W-1:0]    prio;
   } sched_item_type;

   typedef struct packed {
      logic                          dispatched;
      logic [ptts_pkg::THREAD_W-1:0] dthread;
      logic                          dropped;
   } sched_result_type;

   typedef struct packed {
      logic [ptts_pkg::THREAD_W-1:0]  target;
      logic [ptts_pkg::TIMEOUT_W-1:0] value;
   } timer_write_type;

   typedef struct packed {
      sched_item_type   item;
      logic [4:0]       reps;
      logic             known;
      sched_result_type want;
   } directed_row_type;

   localparam sched_result_type NO_RESULT   = '{1'b0, 3'd0, 1'b0};
   localparam sched_result_type DROP_RESULT = '{1'b0, 3'd0, 1'b1};
   localparam sched_result_type PICK_3      = '{1'b1, 3'd3, 1'b0};

   localparam int DIRECTED_ROWS = 18;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{'{ptts_pkg::MODE_DISPATCH,     3'd0, 16'h0000, 8'h00}, 5'd1,  1'b1, NO_RESULT},
      '{'{ptts_pkg::MODE_DONE,         3'd0, 16'h0000, 8'h00}, 5'd1,  1'b1, NO_RESULT},
      '{'{MODE_UNUSED,                 3'd7, 16'hFFFF, 8'hFF}, 5'd1,  1'b1, NO_RESULT},
      '{'{ptts_pkg::MODE_TICK,         3'd0, 16'h0000, 8'h00}, 5'd1,  1'b1, NO_RESULT},
      '{'{ptts_pkg::MODE_REGISTER,     3'd0, 16'hFFFF, 8'h00}, 5'd1,  1'b1, NO_RESULT},
      '{'{ptts_pkg::MODE_REGISTER,     3'd7, 16'h0000, 8'hFF}, 5'd1,  1'b1, NO_RESULT},
      '{'{ptts_pkg::MODE_REGISTER,     3'd3, 16'h0000, 8'hFE}, 5'd1,  1'b1, NO_RESULT},
      '{'{ptts_pkg::MODE_SCHED_THREAD, 3'd7, 16'h0001, 8'h00}, 5'd1,  1'b1, NO_RESULT},
      // thread 7 is ready but sits at the never-picked priority
      '{'{ptts_pkg::MODE_DISPATCH,     3'd0, 16'h0000, 8'h00}, 5'd1,  1'b1, NO_RESULT},
      '{'{ptts_pkg::MODE_SCHED_IRQ,    3'd3, 16'h0001, 8'h00}, 5'd1,  1'b1, NO_RESULT},
      '{'{ptts_pkg::MODE_DISPATCH,     3'd0, 16'h0000, 8'h00}, 5'd1,  1'b1, PICK_3},
      '{'{ptts_pkg::MODE_SCHED_SELF,   3'd5, 16'h0002, 8'h00}, 5'd1,  1'b0, NO_RESULT},
      '{'{ptts_pkg::MODE_DONE,         3'd0, 16'h0000, 8'h00}, 5'd1,  1'b0, NO_RESULT},
      '{'{ptts_pkg::MODE_SCHED_IRQ,    3'd7, 16'h0000, 8'h00}, 5'd1,  1'b0, NO_RESULT},
      '{'{ptts_pkg::MODE_TICK,         3'd0, 16'h0000, 8'h00}, 5'd2,  1'b0, NO_RESULT},
      // fill the thread queue, then overflow it from both writers
      '{'{ptts_pkg::MODE_SCHED_THREAD, 3'd6, 16'h8000, 8'hAA}, 5'd16, 1'b0, NO_RESULT},
      '{'{ptts_pkg::MODE_SCHED_THREAD, 3'd1, 16'h0001, 8'h55}, 5'd1,  1'b1, DROP_RESULT},
      '{'{ptts_pkg::MODE_SCHED_SELF,   3'd2, 16'hFFFF, 8'h00}, 5'd1,  1'b1, DROP_RESULT}
   };

   logic                             clock            = 1'b0;
   logic                             reset            = 1'b1;
   logic                             req_valid        = 1'b0;
   logic                             req_ready;
   logic [ptts_pkg::MODE_W-1:0]      req_mode         = '0;
   logic [ptts_pkg::THREAD_W-1:0]    req_thread       = '0;
   logic [ptts_pkg::TIMEOUT_W-1:0]   req_timeout      = '0;
   logic [ptts_pkg::PRIO_W-1:0]      req_priority_req = '0;
   logic                             rsp_valid;
   logic                             rsp_ready        = 1'b0;
   logic                             rsp_dispatched;
   logic [ptts_pkg::THREAD_W-1:0]    rsp_dispatch_thread;
   logic                             rsp_dropped;
   logic                             csr_write_en     = 1'b0;
   logic [ptts_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [ptts_pkg::CSR_DATA_W-1:0]  csr_write_data   = '0;

   priority_tick_thread_scheduler_top #(
      .NUM_THREADS(NUM_THREADS),
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TIMER_BITS (16)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_thread         (req_thread),
      .req_timeout        (req_timeout),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_dispatched     (rsp_dispatched),
      .rsp_dispatch_thread(rsp_dispatch_thread),
      .rsp_dropped        (rsp_dropped),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // scheduler model state
   logic                           model_ready [NUM_THREADS];
   logic [ptts_pkg::TIMEOUT_W-1:0] model_timer [NUM_THREADS];
   logic [ptts_pkg::PRIO_W-1:0]    model_prio  [NUM_THREADS];
   logic [ptts_pkg::THREAD_W-1:0]  model_running;
   logic [ptts_pkg::TIMEOUT_W-1:0] run_now_val;
   logic [ptts_pkg::TIMEOUT_W-1:0] sleep_val;
   timer_write_type                thread_defer [$];
   timer_write_type                irq_defer [$];

   sched_result_type     pending_outcomes [$];
   sched_result_type     oldest;
   int unsigned          mismatches  = 0;
   int unsigned          items_sent  = 0;
   int unsigned          ticks_seen  = 0;
   int unsigned          picks_seen  = 0;
   int unsigned          drops_seen  = 0;
   int unsigned          cycle_count = 0;
   int unsigned          stall_left  = 0;
   bit                   idle_on     = 1'b1;

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      mismatches++;
      // keep the log short when everything goes wrong
      if (mismatches <= MAX_PRINTED)
         $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   function automatic logic defer_timer_write(input logic to_irq,
                                              input logic [ptts_pkg::THREAD_W-1:0] target,
                                              input logic [ptts_pkg::TIMEOUT_W-1:0] value,
                                              input logic immediate);
      timer_write_type w;
      w.target = target;
      w.value  = value;
      if (to_irq) begin
         if (irq_defer.size() >= QUEUE_DEPTH) return 1'b1;
         irq_defer.push_back(w);
      end else begin
         if (thread_defer.size() >= QUEUE_DEPTH) return 1'b1;
         thread_defer.push_back(w);
      end
      // run-now wins when both codes match
      if (immediate) begin
         if (value == run_now_val) model_ready[target] = 1'b1;
         else if (value == sleep_val) model_ready[target] = 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic sched_result_type apply_item(input sched_item_type it);
      sched_result_type            res;
      timer_write_type             w;
      logic [ptts_pkg::PRIO_W-1:0] best;
      logic                        found;
      int                          pick;
      res = NO_RESULT;
      case (it.mode)
         ptts_pkg::MODE_TICK: begin
            ticks_seen++;
            while (thread_defer.size() != 0) begin
               w = thread_defer.pop_front();
               model_timer[w.target] = w.value;
            end
            while (irq_defer.size() != 0) begin
               w = irq_defer.pop_front();
               model_timer[w.target] = w.value;
            end
            for (int i = 0; i < NUM_THREADS; i++) begin
               if (model_timer[i] != '0) begin
                  model_timer[i] = model_timer[i] - 1'b1;
                  if (model_timer[i] == '0) model_ready[i] = 1'b1;
               end
            end
         end
         ptts_pkg::MODE_SCHED_THREAD:
            res.dropped = defer_timer_write(1'b0, it.thread, it.timeout, 1'b1);
         ptts_pkg::MODE_SCHED_IRQ:
            res.dropped = defer_timer_write(1'b1, it.thread, it.timeout, 1'b1);
         ptts_pkg::MODE_SCHED_SELF:
            res.dropped = defer_timer_write(1'b0, model_running, it.timeout, 1'b0);
         ptts_pkg::MODE_DISPATCH: begin
            best  = ptts_pkg::PRIO_NEVER;
            found = 1'b0;
            pick  = 0;
            for (int i = 0; i < NUM_THREADS; i++) begin
               if (model_ready[i] && model_prio[i] < best) begin
                  best  = model_prio[i];
                  pick  = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               model_running  = pick[ptts_pkg::THREAD_W-1:0];
               res.dispatched = 1'b1;
               res.dthread    = pick[ptts_pkg::THREAD_W-1:0];
               picks_seen++;
            end
         end
         ptts_pkg::MODE_DONE: model_ready[model_running] = 1'b0;
         ptts_pkg::MODE_REGISTER: begin
            model_prio[it.thread]  = it.prio;
            model_timer[it.thread] = it.timeout;
         end
         default: ;
      endcase
      if (res.dropped) drops_seen++;
      items_sent++;
      return res;
   endfunction

   task automatic send_item(input sched_item_type it, input logic known,
                            input sched_result_type want);
      sched_result_type predicted;
      if (idle_on && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= it.mode;
      req_thread       <= it.thread;
      req_timeout      <= it.timeout;
      req_priority_req <= it.prio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_item(it);
      pending_outcomes.push_back(known ? want : predicted);
   endtask

   task automatic write_codes(input logic [ptts_pkg::CSR_DATA_W-1:0] run_now,
                              input logic [ptts_pkg::CSR_DATA_W-1:0] sleep);
      // hold until the block is idle
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= ptts_pkg::CSR_RUN_NOW;
      csr_write_data <= run_now;
      @(posedge clock);
      csr_index      <= ptts_pkg::CSR_SLEEP;
      csr_write_data <= sleep;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      run_now_val = run_now;
      sleep_val   = sleep;
   endtask

   function automatic sched_item_type random_item(input int unsigned tick_pct);
      sched_item_type it;
      int unsigned    pick;
      it.thread = ptts_pkg::THREAD_W'($urandom_range(NUM_THREADS - 1));
      case ($urandom_range(9))
         0, 1:    it.timeout = run_now_val;
         2:       it.timeout = sleep_val;
         3, 4, 5: it.timeout = ptts_pkg::TIMEOUT_W'($urandom_range(6));
         6:       it.timeout = '1;
         default: it.timeout = ptts_pkg::TIMEOUT_W'($urandom);
      endcase
      // bias priorities toward ties and the never-picked value
      case ($urandom_range(7))
         0:       it.prio = ptts_pkg::PRIO_NEVER;
         1:       it.prio = '0;
         2, 3, 4: it.prio = ptts_pkg::PRIO_W'($urandom_range(3));
         default: it.prio = ptts_pkg::PRIO_W'($urandom);
      endcase
      if ($urandom_range(99) < tick_pct) begin
         it.mode = ptts_pkg::MODE_TICK;
      end else begin
         pick = $urandom_range(99);
         if (pick < 28)      it.mode = ptts_pkg::MODE_SCHED_THREAD;
         else if (pick < 48) it.mode = ptts_pkg::MODE_SCHED_IRQ;
         else if (pick < 58) it.mode = ptts_pkg::MODE_SCHED_SELF;
         else if (pick < 74) it.mode = ptts_pkg::MODE_DISPATCH;
         else if (pick < 84) it.mode = ptts_pkg::MODE_DONE;
         else if (pick < 97) it.mode = ptts_pkg::MODE_REGISTER;
         else                it.mode = MODE_UNUSED;
      end
      return it;
   endfunction

   // response stalls
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(4) == 0) begin
         stall_left <= $urandom_range(2);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   // scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response beat with nothing outstanding", 0, 1);
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_dispatched !== oldest.dispatched)
               report_mismatch("dispatched", 32'(oldest.dispatched), 32'(rsp_dispatched));
            if (rsp_dispatch_thread !== oldest.dthread)
               report_mismatch("dispatch_thread", 32'(oldest.dthread),
                               32'(rsp_dispatch_thread));
            if (rsp_dropped !== oldest.dropped)
               report_mismatch("dropped", 32'(oldest.dropped), 32'(rsp_dropped));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("priority_tick_thread_scheduler_top: mismatch");
         $finish;
      end
   end

   initial begin
      logic [ptts_pkg::CSR_DATA_W-1:0] phase_run_now [NUM_PHASES];
      logic [ptts_pkg::CSR_DATA_W-1:0] phase_sleep   [NUM_PHASES];
      int unsigned                     tick_pct;

      for (int i = 0; i < NUM_THREADS; i++) begin
         model_ready[i] = 1'b0;
         model_timer[i] = '0;
         model_prio[i]  = ptts_pkg::PRIO_NEVER;
      end
      model_running = '0;
      run_now_val   = ptts_pkg::RUN_NOW_RESET;
      sleep_val     = ptts_pkg::SLEEP_RESET;

      phase_run_now[0] = '1;
      phase_sleep[0]   = '0;
      phase_run_now[1] = '0;
      phase_sleep[1]   = '1;
      phase_run_now[2] = ptts_pkg::CSR_DATA_W'($urandom);
      phase_sleep[2]   = phase_run_now[2];
      phase_run_now[3] = ptts_pkg::CSR_DATA_W'($urandom_range(1, 4));
      phase_sleep[3]   = ptts_pkg::CSR_DATA_W'($urandom_range(4));
      phase_run_now[4] = ptts_pkg::CSR_DATA_W'($urandom);
      phase_sleep[4]   = ptts_pkg::CSR_DATA_W'($urandom);
      phase_run_now[5] = ptts_pkg::RUN_NOW_RESET;
      phase_sleep[5]   = ptts_pkg::SLEEP_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r])
         for (int k = 0; k < DIRECTED[r].reps; k++)
            send_item(DIRECTED[r].item, DIRECTED[r].known, DIRECTED[r].want);

      tick_pct = 10;
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_codes(phase_run_now[p], phase_sleep[p]);
         // no idling in the closing phase
         if (p == NUM_PHASES - 1) idle_on = 1'b0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // mix in tick-starved segments at random so the queues overflow
            if (n % SEGMENT_ITEMS == 0) tick_pct = ($urandom_range(1) == 0) ? 2 : 12;
            send_item(random_item(tick_pct), 1'b0, NO_RESULT);
         end
      end
      req_valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d items over %0d code settings: %0d ticks, %0d threads dispatched,",
               items_sent, NUM_PHASES + 1, ticks_seen, picks_seen);
      $display("%0d schedule requests dropped on a full queue, %0d mismatches",
               drops_seen, mismatches);
      if (mismatches == 0) begin
         $display("priority_tick_thread_scheduler_top: match");
      end else begin
         $display("priority_tick_thread_scheduler_top: mismatch");
      end
      $finish;
   end

endmodule
